### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the verification checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### design/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the sync frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int DATA_W             = 8;
    localparam int BYTE_INDEX_W       = 6;
    localparam int PAYLOAD_BYTES_DEF  = 16;
    localparam int TOKQ_DEPTH         = 2;

    localparam logic [DATA_W-1:0] FIRST_SYNC_RESET  = 8'hAA;
    localparam logic [DATA_W-1:0] SECOND_SYNC_RESET = 8'hBB;

    localparam logic REG_IDX_FIRST_SYNC  = 1'b0;
    localparam logic REG_IDX_SECOND_SYNC = 1'b1;

    typedef struct packed {
        logic                    en;
        logic                    bank;
        logic [BYTE_INDEX_W-1:0] addr;
        logic [DATA_W-1:0]       data;
    } sfr_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } sfr_tok_t;

endpackage

### design/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Sync hunt, payload capture into a double-buffered store and checksum test.
// ----------------------------------------------------------------------------
module sfr_front #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [sfr_pkg::DATA_W-1:0] rx_byte,
    input  logic [sfr_pkg::DATA_W-1:0] first_sync,
    input  logic [sfr_pkg::DATA_W-1:0] second_sync,
    input  sfr_pkg::sfr_tok_t         rel,
    output logic                      full,
    output sfr_pkg::sfr_wr_t          wr,
    output sfr_pkg::sfr_tok_t         tok
);

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_CHECK  = 2'd3;

    logic [1:0]                 phase_reg, phase_next;
    logic [IDX_W-1:0]           count_reg, count_next;
    logic [sfr_pkg::DATA_W-1:0] sum_reg, sum_next;
    logic                       wr_bank_reg, wr_bank_next;
    logic [1:0]                 busy_reg, busy_next;
    logic                       accept;

    assign full   = busy_reg[wr_bank_reg];
    assign accept = push && !full;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        wr           = '0;
        tok          = '0;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (accept)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (rx_byte == first_sync)
                    begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    if (rx_byte == second_sync)
                    begin
                        phase_next = PH_DATA;
                        count_next = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_DATA:
                begin
                    wr.en    = 1'b1;
                    wr.bank  = wr_bank_reg;
                    wr.addr  = sfr_pkg::BYTE_INDEX_W'(count_reg);
                    wr.data  = rx_byte;
                    sum_next = sum_reg + rx_byte;
                    if (count_reg == LAST_IDX)
                    begin
                        count_next = '0;
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_CHECK:
                begin
                    if (rx_byte == sum_reg)
                    begin
                        tok.valid              = 1'b1;
                        tok.bank               = wr_bank_reg;
                        busy_next[wr_bank_reg] = 1'b1;
                        wr_bank_next           = ~wr_bank_reg;
                    end
                    phase_next = PH_FIRST;
                    count_next = '0;
                    sum_next   = '0;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            count_reg   <= '0;
            sum_reg     <= '0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

### design/sfr_tokq.sv
// ----------------------------------------------------------------------------
// sfr_tokq
// Short queue of finished frame buffers between the front and back parts.
// ----------------------------------------------------------------------------
module sfr_tokq (
    input  logic              clk,
    input  logic              rst_n,
    input  sfr_pkg::sfr_tok_t tok,
    input  logic              pop,
    output sfr_pkg::sfr_tok_t head
);

    localparam int PTR_W = $clog2(sfr_pkg::TOKQ_DEPTH);

    logic [sfr_pkg::TOKQ_DEPTH-1:0] bank_reg;
    logic [PTR_W-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]                 count_reg, count_next;
    logic                           do_pop;

    assign head.valid = (count_reg != '0);
    assign head.bank  = bank_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (tok.valid)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (tok.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!tok.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok.valid)
        begin
            bank_reg[wr_ptr_reg] <= tok.bank;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Payload store and burst drain of frames that passed the checksum.
// ----------------------------------------------------------------------------
module sfr_back #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sfr_pkg::sfr_wr_t                wr,
    input  sfr_pkg::sfr_tok_t               head,
    input  logic                            pop,
    output logic                            tok_pop,
    output sfr_pkg::sfr_tok_t               rel,
    output logic                            empty,
    output logic [sfr_pkg::DATA_W-1:0]       payload_byte,
    output logic [sfr_pkg::BYTE_INDEX_W-1:0] byte_index,
    output logic                            last_of_frame
);

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    logic [sfr_pkg::DATA_W-1:0] mem [2][PAYLOAD_BYTES];
    logic [sfr_pkg::DATA_W-1:0] mem_q_reg;

    logic [IDX_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]           s1_idx_reg;
    logic                       s1_last_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [sfr_pkg::DATA_W-1:0] out_data_reg;
    logic [IDX_W-1:0]           out_idx_reg;
    logic                       out_last_reg;
    logic                       s1_adv;
    logic                       issue;
    logic                       issue_last;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || pop);
    assign issue      = head.valid && (!s1_valid_reg || s1_adv);
    assign issue_last = (rd_idx_reg == LAST_IDX);
    assign tok_pop    = issue && issue_last;
    assign rel.valid  = tok_pop;
    assign rel.bank   = head.bank;

    assign empty         = !out_valid_reg;
    assign payload_byte  = out_data_reg;
    assign byte_index    = sfr_pkg::BYTE_INDEX_W'(out_idx_reg);
    assign last_of_frame = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.bank][wr.addr[IDX_W-1:0]] <= wr.data;
        end
        if (issue)
        begin
            mem_q_reg <= mem[head.bank][rd_idx_reg];
        end
    end

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            rd_idx_next = issue_last ? '0 : rd_idx_reg + 1'b1;
        end
        if (issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg  <= rd_idx_reg;
            s1_last_reg <= issue_last;
        end
        if (s1_adv)
        begin
            out_data_reg <= mem_q_reg;
            out_idx_reg  <= s1_idx_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/sync_frame_receiver_sum8_unit.sv
// ----------------------------------------------------------------------------
// sync_frame_receiver_sum8_unit
// Two-byte sync, fixed-length frame receiver with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while full is low; full rises only while
// both payload buffers hold frames whose last byte has not yet been read from
// the store. A good frame is queued once its checksum byte is taken; its bytes
// pass a store read register and an output register, and the burst drains one
// byte per cycle while pop is high. Reset clears the sync state and all queues;
// the sync registers return to 0xAA and 0xBB. The payload store is not cleared.
module sync_frame_receiver_sum8_unit #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [sfr_pkg::DATA_W-1:0]       rx_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [sfr_pkg::DATA_W-1:0]       payload_byte,
    output logic [sfr_pkg::BYTE_INDEX_W-1:0] byte_index,
    output logic                            last_of_frame,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [sfr_pkg::DATA_W-1:0] first_sync_reg;
    logic [sfr_pkg::DATA_W-1:0] second_sync_reg;
    logic                       cfg_write;
    logic [sfr_pkg::DATA_W-1:0] rd_value;
    sfr_pkg::sfr_wr_t           wr;
    sfr_pkg::sfr_tok_t          tok;
    sfr_pkg::sfr_tok_t          head;
    sfr_pkg::sfr_tok_t          rel;
    logic                       tok_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= sfr_pkg::FIRST_SYNC_RESET;
            second_sync_reg <= sfr_pkg::SECOND_SYNC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sfr_pkg::REG_IDX_FIRST_SYNC:  first_sync_reg  <= pwdata[7:0];
                sfr_pkg::REG_IDX_SECOND_SYNC: second_sync_reg <= pwdata[7:0];
                default:                      first_sync_reg  <= first_sync_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sfr_pkg::REG_IDX_FIRST_SYNC:  rd_value = first_sync_reg;
            sfr_pkg::REG_IDX_SECOND_SYNC: rd_value = second_sync_reg;
            default:                      rd_value = '0;
        endcase
    end

    assign prdata = {24'd0, rd_value};

    sfr_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .rx_byte     (rx_byte),
        .first_sync  (first_sync_reg),
        .second_sync (second_sync_reg),
        .rel         (rel),
        .full        (full),
        .wr          (wr),
        .tok         (tok)
    );

    sfr_tokq u_tokq (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok),
        .pop   (tok_pop),
        .head  (head)
    );

    sfr_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .head          (head),
        .pop           (pop),
        .tok_pop       (tok_pop),
        .rel           (rel),
        .empty         (empty),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .last_of_frame (last_of_frame)
    );

endmodule

### design/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker #(
    parameter int PAYLOAD_BYTES = sfr_pkg::PAYLOAD_BYTES_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            empty,
    input logic                            pop,
    input logic [sfr_pkg::DATA_W-1:0]       payload_byte,
    input logic [sfr_pkg::BYTE_INDEX_W-1:0] byte_index,
    input logic                            last_of_frame
);

    localparam logic [sfr_pkg::BYTE_INDEX_W-1:0] LAST_IDX =
        sfr_pkg::BYTE_INDEX_W'(PAYLOAD_BYTES - 1);

    logic [sfr_pkg::BYTE_INDEX_W-1:0] exp_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (!empty && pop)
        begin
            exp_idx_reg <= last_of_frame ? '0 : exp_idx_reg + 1'b1;
        end
    end

    `SFR_ASSERT_NEXT(a_hold_stalled, clk, rst_n, !empty && !pop, !empty && $stable(payload_byte) && $stable(byte_index) && $stable(last_of_frame))
    `SFR_ASSERT_SAME(a_index_order, clk, rst_n, !empty, byte_index == exp_idx_reg)
    `SFR_ASSERT_SAME(a_last_marks_end, clk, rst_n, !empty, last_of_frame == (byte_index == LAST_IDX))

endmodule

bind sync_frame_receiver_sum8_unit sfr_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_sfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .last_of_frame (last_of_frame)
);
